// ----- hw/rtl/multiplexed_sonar_ranger_core_assert.svh -----
// Assertion macros for the sonar ranger checker.
// Depends on nothing; included by the checker file.
`ifndef MULTIPLEXED_SONAR_RANGER_CORE_ASSERT_SVH
`define MULTIPLEXED_SONAR_RANGER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define MSR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sonar ranger check failed: same-cycle rule");

// Next-cycle implication, sampled on the rising clock edge.
`define MSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sonar ranger check failed: next-cycle rule");

`endif

// ----- hw/rtl/msr_pkg.sv -----
// Shared types and constants for the multiplexed sonar ranger.
// No dependencies; used by msr_math and the top level.
package msr_pkg;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register map index, taken from paddr[3:2]
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_ENABLE  = 2'd1;
  localparam logic [1:0] REG_SCALE   = 2'd2;
  localparam logic [1:0] REG_DELAY   = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd20000;
  localparam logic [2:0]  ENABLE_RESET  = 3'd0;
  localparam logic [15:0] SCALE_RESET   = 16'd11239;
  localparam logic [15:0] DELAY_RESET   = 16'd0;

  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
  localparam logic [15:0] SAT16       = 16'hFFFF;
  localparam logic [1:0]  MISS_MAX    = 2'd3;
  localparam int          ECHO_PINS   = 3;

  // floor(7*x/10) = (x * 7 * ceil(2^22/10)) >> 22, exact for 7*x < 699050
  localparam int          DECAY_SHIFT = 22;
  localparam logic [21:0] DECAY_MUL   = 22'd2936017;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_PINGED = 4'b0010,
    PH_HIGH   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  localparam logic [1:0] CODE_IDLE   = 2'd0;
  localparam logic [1:0] CODE_PINGED = 2'd1;
  localparam logic [1:0] CODE_HIGH   = 2'd2;
  localparam logic [1:0] CODE_DONE   = 2'd3;

  typedef struct packed {
    logic        timed_out;
    logic [16:0] width;
    logic [15:0] avg_old;
    logic [1:0]  miss_old;
  } meas_req_t;

  typedef struct packed {
    logic [15:0] raw;
    logic [15:0] avg;
    logic [1:0]  miss;
  } meas_res_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    unique case (ph)
      PH_IDLE:   code = CODE_IDLE;
      PH_PINGED: code = CODE_PINGED;
      PH_HIGH:   code = CODE_HIGH;
      PH_DONE:   code = CODE_DONE;
      default:   code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/msr_math.sv -----
// Distance arithmetic of the sonar ranger: raw scaling, filter, miss count.
// Depends on msr_pkg.
module msr_math
  import msr_pkg::*;
(
  input  meas_req_t   req,
  input  logic [15:0] timeout_us,
  input  logic [15:0] scale_q16,
  input  logic [15:0] echo_delay_us,
  output meas_res_t   res
);

  logic [16:0] delay_ext;
  logic [16:0] span;
  logic [16:0] operand;
  logic [32:0] raw_prod;
  logic [15:0] raw;
  logic [37:0] decay_prod;
  logic [15:0] decay;
  logic [18:0] echo_sum;
  logic [15:0] echo_avg;
  logic [19:0] ten_raw;
  logic [15:0] ten_avg;
  logic [1:0]  miss_new;

  assign delay_ext = {1'b0, echo_delay_us};
  assign span      = (req.width > delay_ext) ? (req.width - delay_ext) : 17'd0;
  assign operand   = req.timed_out ? {1'b0, timeout_us} : span;

  assign raw_prod = 33'(operand) * 33'(scale_q16);
  assign raw      = (raw_prod[32]) ? SAT16 : raw_prod[31:16];

  // decay runs beside the raw multiply, not after it
  assign decay_prod = 38'(req.avg_old) * 38'(DECAY_MUL);
  assign decay      = decay_prod[DECAY_SHIFT +: 16];

  assign echo_sum = 19'(decay) + 19'(raw) + 19'({raw, 1'b0});
  assign echo_avg = (echo_sum > 19'(SAT16)) ? SAT16 : echo_sum[15:0];

  assign ten_raw = 20'({raw, 3'b000}) + 20'({raw, 1'b0});
  assign ten_avg = (ten_raw > 20'(SAT16)) ? SAT16 : ten_raw[15:0];

  assign miss_new = (req.miss_old == MISS_MAX) ? MISS_MAX : req.miss_old + 2'd1;

  always_comb begin
    res.raw = raw;
    if (req.timed_out) begin
      res.miss = miss_new;
      res.avg  = (miss_new == MISS_MAX) ? ten_avg : req.avg_old;
    end else begin
      res.miss = 2'd0;
      res.avg  = echo_avg;
    end
  end

endmodule

// ----- hw/rtl/multiplexed_sonar_ranger_core.sv -----
// Top level of the multiplexed sonar ranger: handshakes, APB registers, ranging state.
// Depends on msr_pkg and msr_math.
//
// Each input beat is one microsecond tick carrying the echo pin levels of up
// to three sonars; each tick yields exactly one result beat. The block pings
// the enabled sonars in round-robin order (trigger_valid/trigger_sonar), times
// the active sonar's echo pulse from its rising to its falling edge, and on
// the tick after the pulse ends reports raw_mm = (width - echo_delay_us,
// floored at zero) * scale_q16 / 65536 and a filtered avg_value =
// floor(0.7 * avg) + 3 * raw. If no echo ends within timeout_us of the ping,
// it reports a timeout with raw_mm at the full-range distance, and after
// three misses in a row avg_value jumps to ten times that. Both saturate at
// 65535. Rate: one tick per clock cycle while result_stall is low. A tick
// is captured in an input register, and then all of its work (elapsed
// count, edge detect, one 17x16 multiply for raw beside one 16x22 multiply
// for the filter decay) runs in a single pass into the result register,
// which raises result_valid. The result register and the input register
// together buffer two beats, so tick_stall rises only when both are full
// and the result side is stalled.
// Configuration registers sit at byte addresses 0 (timeout_us), 4
// (enable_mask), 8 (scale_q16) and 12 (echo_delay_us); write them only while
// no tick is in flight.
module multiplexed_sonar_ranger_core
  import msr_pkg::*;
#(
  parameter int SONAR_COUNT = 3
) (
  input  logic               clk,
  input  logic               rst,
  // tick input channel
  input  logic               tick_valid,
  output logic               tick_stall,
  input  logic [2:0]         echo_levels,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic               trigger_valid,
  output logic [2:0]         trigger_sonar,
  output logic               update_valid,
  output logic [2:0]         update_sonar,
  output logic               timed_out,
  output logic [15:0]        raw_mm,
  output logic [15:0]        avg_value,
  output logic [1:0]         phase,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W = (SONAR_COUNT > 1) ? $clog2(SONAR_COUNT) : 1;
  localparam int EN_W  = 1 << IDX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] timeout_us;
  logic [2:0]  enable_mask;
  logic [15:0] scale_q16;
  logic [15:0] echo_delay_us;
  logic        cfg_write;
  logic [1:0]  cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us    <= TIMEOUT_RESET;
      enable_mask   <= ENABLE_RESET;
      scale_q16     <= SCALE_RESET;
      echo_delay_us <= DELAY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TIMEOUT: timeout_us    <= pwdata[15:0];
        REG_ENABLE:  enable_mask   <= pwdata[2:0];
        REG_SCALE:   scale_q16     <= pwdata[15:0];
        REG_DELAY:   echo_delay_us <= pwdata[15:0];
        default:     timeout_us    <= timeout_us;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_TIMEOUT: prdata = PDATA_W'(timeout_us);
      REG_ENABLE:  prdata = PDATA_W'(enable_mask);
      REG_SCALE:   prdata = PDATA_W'(scale_q16);
      REG_DELAY:   prdata = PDATA_W'(echo_delay_us);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the single-pass step, result register
  // holds the beat until the consumer takes it.
  // ---------------------------------------------------------------------------
  logic       in_full;
  logic [2:0] in_levels;
  logic       go;
  logic       in_take;

  assign go         = in_full & (~result_valid | ~result_stall);
  assign tick_stall = in_full & ~go;
  assign in_take    = tick_valid & ~tick_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_levels <= echo_levels;
    end
  end

  // ---------------------------------------------------------------------------
  // Ranging state
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] active_index;
  phase_t           phase_reg;
  logic [16:0]      elapsed_us;
  logic [16:0]      pulse_begin;
  logic [16:0]      pulse_width;
  logic [2:0]       prev_levels;
  logic [1:0]       miss_count [SONAR_COUNT];
  logic [15:0]      avg_store  [SONAR_COUNT];

  // Enabled sonars; mask bits past the sonar count are ignored
  logic [EN_W-1:0] en_vec;
  always_comb begin
    en_vec = '0;
    for (int i = 0; i < SONAR_COUNT; i++) begin
      if (i < ECHO_PINS) begin
        en_vec[i] = enable_mask[i];
      end
    end
  end

  // Step 1: count the tick, then close out a finished echo or a timeout
  logic [16:0] elapsed_inc;
  logic        upd_echo;
  logic        upd_tmo;
  logic        upd_any;
  phase_t      phase_a;

  assign elapsed_inc = (elapsed_us < ELAPSED_MAX) ? elapsed_us + 17'd1 : elapsed_us;
  assign upd_echo    = (phase_reg == PH_DONE);
  assign upd_tmo     = ~upd_echo & (phase_reg != PH_IDLE) & (elapsed_inc > {1'b0, timeout_us});
  assign upd_any     = upd_echo | upd_tmo;
  assign phase_a     = upd_any ? PH_IDLE : phase_reg;

  meas_req_t meas_req;
  meas_res_t meas_res;

  assign meas_req.timed_out = upd_tmo;
  assign meas_req.width     = pulse_width;
  assign meas_req.avg_old   = avg_store[active_index];
  assign meas_req.miss_old  = miss_count[active_index];

  msr_math u_math (
    .req           (meas_req),
    .timeout_us    (timeout_us),
    .scale_q16     (scale_q16),
    .echo_delay_us (echo_delay_us),
    .res           (meas_res)
  );

  // Step 2: when idle, ping the next enabled sonar after the active one.
  // Scan the candidates from farthest to nearest so the nearest wins.
  logic [IDX_W:0]   cand;
  logic [IDX_W-1:0] next_index;

  always_comb begin
    next_index = active_index;
    cand       = '0;
    for (int k = SONAR_COUNT; k >= 1; k--) begin
      cand = {1'b0, active_index} + (IDX_W+1)'(k);
      if (cand >= (IDX_W+1)'(SONAR_COUNT)) begin
        cand = cand - (IDX_W+1)'(SONAR_COUNT);
      end
      if (en_vec[cand[IDX_W-1:0]]) begin
        next_index = cand[IDX_W-1:0];
      end
    end
  end

  logic             ping;
  logic [IDX_W-1:0] index_b;
  logic [16:0]      elapsed_b;
  phase_t           phase_b;

  assign ping      = (phase_a == PH_IDLE) & (|en_vec);
  assign index_b   = ping ? next_index : active_index;
  assign elapsed_b = ping ? 17'd0 : elapsed_inc;
  assign phase_b   = ping ? PH_PINGED : phase_a;

  // Step 3: edge detect on the active sonar's echo pin
  logic pin_now;
  logic pin_before;

  always_comb begin
    pin_now    = 1'b0;
    pin_before = 1'b0;
    for (int i = 0; i < ECHO_PINS; i++) begin
      if (32'(index_b) == i) begin
        pin_now    = in_levels[i];
        pin_before = prev_levels[i];
      end
    end
  end

  logic   rise;
  logic   fall;
  phase_t phase_c;

  assign rise = (phase_b == PH_PINGED) & pin_now & ~pin_before;
  assign fall = (phase_b == PH_HIGH) & ~pin_now & pin_before;

  always_comb begin
    priority if (rise) begin
      phase_c = PH_HIGH;
    end else if (fall) begin
      phase_c = PH_DONE;
    end else begin
      phase_c = phase_b;
    end
  end

  // Commit the step on each processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      active_index <= '0;
      phase_reg    <= PH_IDLE;
      elapsed_us   <= '0;
      pulse_begin  <= '0;
      pulse_width  <= '0;
      prev_levels  <= '0;
      for (int i = 0; i < SONAR_COUNT; i++) begin
        miss_count[i] <= '0;
        avg_store[i]  <= '0;
      end
    end else if (go) begin
      active_index <= index_b;
      phase_reg    <= phase_c;
      elapsed_us   <= elapsed_b;
      prev_levels  <= in_levels;
      if (rise) begin
        pulse_begin <= elapsed_b;
      end
      // hold the width, not the end time; the delay is applied at report time
      if (fall) begin
        pulse_width <= (elapsed_b > pulse_begin) ? elapsed_b - pulse_begin : 17'd0;
      end
      if (upd_any) begin
        miss_count[active_index] <= meas_res.miss;
        avg_store[active_index]  <= meas_res.avg;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go) begin
      result_valid <= 1'b1;
    end else if (~result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      trigger_valid <= ping;
      trigger_sonar <= ping ? 3'(next_index) : 3'd0;
      update_valid  <= upd_any;
      update_sonar  <= upd_any ? 3'(active_index) : 3'd0;
      timed_out     <= upd_tmo;
      raw_mm        <= upd_any ? meas_res.raw : 16'd0;
      avg_value     <= upd_any ? meas_res.avg : 16'd0;
      phase         <= phase_code(phase_c);
    end
  end

endmodule

// ----- hw/rtl/msr_checker.sv -----
// Port-level checker for the multiplexed sonar ranger, bound to the top level.
// Depends on multiplexed_sonar_ranger_core_assert.svh and msr_pkg.
`include "multiplexed_sonar_ranger_core_assert.svh"

module msr_checker
  import msr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic        trigger_valid,
  input logic [2:0]  trigger_sonar,
  input logic        update_valid,
  input logic [2:0]  update_sonar,
  input logic        timed_out,
  input logic [15:0] raw_mm,
  input logic [15:0] avg_value,
  input logic [1:0]  phase
);

  // a stalled beat holds
  `MSR_ASSERT_NEXT(a_stall_hold, clk, rst, result_valid && result_stall, result_valid && $stable(raw_mm) && $stable(avg_value) && $stable(phase))

  // a fresh ping leaves the phase pinged or already in the echo
  `MSR_ASSERT_IMPLY(a_ping_phase, clk, rst, result_valid && trigger_valid, phase == CODE_PINGED || phase == CODE_HIGH)

  // fields of an absent update read zero
  `MSR_ASSERT_IMPLY(a_no_update_zero, clk, rst, result_valid && !update_valid, raw_mm == 16'd0 && avg_value == 16'd0 && !timed_out && update_sonar == 3'd0)

  // no ping means no sonar index
  `MSR_ASSERT_IMPLY(a_no_ping_zero, clk, rst, result_valid && !trigger_valid, trigger_sonar == 3'd0)

endmodule

bind multiplexed_sonar_ranger_core msr_checker u_msr_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .trigger_valid (trigger_valid),
  .trigger_sonar (trigger_sonar),
  .update_valid  (update_valid),
  .update_sonar  (update_sonar),
  .timed_out     (timed_out),
  .raw_mm        (raw_mm),
  .avg_value     (avg_value),
  .phase         (phase)
);
